// ===== rtl/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, limits and name tables for the request header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	// field limits, a field tags at most LIMIT-1 bytes
	localparam int METHOD_MAX    = 16;
	localparam int PATH_MAX_LEN  = 256;
	localparam int QUERY_MAX_LEN = 256;
	localparam int VALUE_MAX_LEN = 128;
	localparam int HEADER_MAX    = 4096;

	localparam int FIELD_MAX_A = (METHOD_MAX > PATH_MAX_LEN) ? METHOD_MAX : PATH_MAX_LEN;
	localparam int FIELD_MAX_B = (QUERY_MAX_LEN > VALUE_MAX_LEN) ? QUERY_MAX_LEN : VALUE_MAX_LEN;
	localparam int FIELD_MAX   = (FIELD_MAX_A > FIELD_MAX_B) ? FIELD_MAX_A : FIELD_MAX_B;
	localparam int FCNT_W      = $clog2(FIELD_MAX);
	localparam int BCNT_W      = $clog2(HEADER_MAX + 1);

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SP    = 8'd32;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_QMARK = 8'd63;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UP_A  = 8'd65;
	localparam logic [7:0] CH_UP_Z  = 8'd90;

	// bit positions in the header name match flags
	localparam int HB_LENGTH = 0;
	localparam int HB_RANGE  = 1;
	localparam int HB_ACCEPT = 2;
	localparam int HB_CONN   = 3;
	localparam int NUM_HDRS  = 4;

	// names right aligned, first character in the highest used byte
	localparam logic [111:0] HDR_NAME [NUM_HDRS] = '{
		112'("content-length"), 112'("range"), 112'("accept"), 112'("connection")
	};
	localparam int HDR_LEN [NUM_HDRS] = '{14, 5, 6, 10};

	localparam logic [39:0] CLOSE_WORD = "close";
	localparam logic [2:0]  CLOSE_LEN  = 3'd5;

	typedef enum logic [9:0] {
		PH_METHOD = 10'b00_0000_0001,
		PH_PATH   = 10'b00_0000_0010,
		PH_QUERY  = 10'b00_0000_0100,
		PH_LINE   = 10'b00_0000_1000,
		PH_NAME   = 10'b00_0001_0000,
		PH_SKIP   = 10'b00_0010_0000,
		PH_VALUE  = 10'b00_0100_0000,
		PH_EOL    = 10'b00_1000_0000,
		PH_END    = 10'b01_0000_0000,
		PH_DONE   = 10'b10_0000_0000
	} phase_t;

	typedef enum logic [2:0] {
		TAG_NONE   = 3'd0,
		TAG_METHOD = 3'd1,
		TAG_PATH   = 3'd2,
		TAG_QUERY  = 3'd3,
		TAG_RANGE  = 3'd4,
		TAG_ACCEPT = 3'd5
	} field_tag_t;

	typedef struct packed {
		phase_t              phase;
		logic [FCNT_W-1:0]   field_count;
		logic [BCNT_W-1:0]   byte_count;
		logic [NUM_HDRS-1:0] name_flags;
		logic [7:0]          name_len;
		logic [2:0]          close_pos;
		logic                close_ok;
		logic [31:0]         length_acc;
		logic                length_seen;
		logic                keep_alive;
		logic                last_cr;
		logic                line_empty;
	} hrhp_state_t;

	localparam hrhp_state_t ST_RESET = '{
		phase:       PH_METHOD,
		field_count: '0,
		byte_count:  '0,
		name_flags:  '1,
		name_len:    8'd0,
		close_pos:   3'd0,
		close_ok:    1'b1,
		length_acc:  32'd0,
		length_seen: 1'b0,
		keep_alive:  1'b1,
		last_cr:     1'b0,
		line_empty:  1'b1
	};

	typedef struct packed {
		logic [7:0]  out_byte;
		field_tag_t  field_tag;
		logic        headers_done;
		logic        has_length;
		logic [31:0] content_length;
		logic        keep_alive;
		logic        overflow;
	} hrhp_result_t;

	function automatic logic [7:0] hdr_char(input logic [1:0] idx, input logic [7:0] pos);
		logic [7:0] sel;
		sel = 8'(HDR_LEN[idx]) - 8'd1 - pos;
		return (pos < 8'(HDR_LEN[idx])) ? HDR_NAME[idx][{sel[3:0], 3'b000} +: 8] : 8'd0;
	endfunction

	function automatic logic [7:0] close_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = CLOSE_WORD[39:32];
			3'd1:    ch = CLOSE_WORD[31:24];
			3'd2:    ch = CLOSE_WORD[23:16];
			3'd3:    ch = CLOSE_WORD[15:8];
			3'd4:    ch = CLOSE_WORD[7:0];
			default: ch = 8'd0;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= CH_UP_A && c <= CH_UP_Z) ? c + 8'd32 : c;
	endfunction

endpackage

// ===== rtl/hrhp_parser.sv =====
// ----------------------------------------------------------------------------
// hrhp_parser
// Parse state and its next-state logic; gives the result for the byte
// presented and advances the state when the byte is taken.
// ----------------------------------------------------------------------------
module hrhp_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            in_byte,
	input  logic                  new_request,
	output hrhp_pkg::hrhp_result_t result
);

	hrhp_pkg::hrhp_state_t state_q;
	hrhp_pkg::hrhp_state_t cur;
	hrhp_pkg::hrhp_state_t nxt;
	hrhp_pkg::field_tag_t  tag;
	logic                  done;
	logic                  ovf;
	logic                  val_byte;
	logic                  end_line;
	logic [7:0]            b_low;
	logic [35:0]           acc_x10;
	logic [3:0]            keep;

	assign b_low = hrhp_pkg::to_lower(in_byte);

	always_comb begin
		cur      = new_request ? hrhp_pkg::ST_RESET : state_q;
		nxt      = cur;
		tag      = hrhp_pkg::TAG_NONE;
		done     = 1'b0;
		ovf      = 1'b0;
		val_byte = 1'b0;
		end_line = 1'b0;
		keep     = 4'd0;
		acc_x10  = {1'b0, cur.length_acc, 3'b000} + {3'b000, cur.length_acc, 1'b0}
			+ 36'(in_byte - hrhp_pkg::CH_ZERO);
		if (cur.phase != hrhp_pkg::PH_DONE) begin
			if (cur.byte_count >= hrhp_pkg::BCNT_W'(hrhp_pkg::HEADER_MAX)) begin
				ovf = 1'b1;
			end else begin
				nxt.byte_count = cur.byte_count + 1'b1;
				end_line = (in_byte == hrhp_pkg::CH_LF) && cur.last_cr && cur.line_empty;
				case (cur.phase)
					hrhp_pkg::PH_METHOD: begin
						if (in_byte == hrhp_pkg::CH_CR) begin
							nxt.phase = hrhp_pkg::PH_EOL;
						end else if (in_byte == hrhp_pkg::CH_SP) begin
							nxt.phase       = hrhp_pkg::PH_PATH;
							nxt.field_count = '0;
						end else if (cur.field_count <
								hrhp_pkg::FCNT_W'(hrhp_pkg::METHOD_MAX - 1)) begin
							nxt.field_count = cur.field_count + 1'b1;
							tag             = hrhp_pkg::TAG_METHOD;
						end
					end
					hrhp_pkg::PH_PATH: begin
						if (in_byte == hrhp_pkg::CH_CR) begin
							nxt.phase = hrhp_pkg::PH_EOL;
						end else if (in_byte == hrhp_pkg::CH_SP) begin
							nxt.phase = hrhp_pkg::PH_LINE;
						end else if (in_byte == hrhp_pkg::CH_QMARK) begin
							nxt.phase       = hrhp_pkg::PH_QUERY;
							nxt.field_count = '0;
						end else if (cur.field_count <
								hrhp_pkg::FCNT_W'(hrhp_pkg::PATH_MAX_LEN - 1)) begin
							nxt.field_count = cur.field_count + 1'b1;
							tag             = hrhp_pkg::TAG_PATH;
						end
					end
					hrhp_pkg::PH_QUERY: begin
						if (in_byte == hrhp_pkg::CH_CR) begin
							nxt.phase = hrhp_pkg::PH_EOL;
						end else if (in_byte == hrhp_pkg::CH_SP) begin
							nxt.phase = hrhp_pkg::PH_LINE;
						end else if (cur.field_count <
								hrhp_pkg::FCNT_W'(hrhp_pkg::QUERY_MAX_LEN - 1)) begin
							nxt.field_count = cur.field_count + 1'b1;
							tag             = hrhp_pkg::TAG_QUERY;
						end
					end
					hrhp_pkg::PH_LINE: begin
						if (in_byte == hrhp_pkg::CH_CR) begin
							nxt.phase = hrhp_pkg::PH_EOL;
						end
					end
					hrhp_pkg::PH_EOL: begin
						// byte after CR is skipped, a new header name starts
						nxt.phase      = hrhp_pkg::PH_NAME;
						nxt.name_flags = '1;
						nxt.name_len   = 8'd0;
					end
					hrhp_pkg::PH_NAME: begin
						if (in_byte == hrhp_pkg::CH_CR) begin
							nxt.phase = (cur.name_len == 8'd0) ? hrhp_pkg::PH_END
								: hrhp_pkg::PH_EOL;
						end else if (in_byte == hrhp_pkg::CH_COLON) begin
							for (int i = 0; i < hrhp_pkg::NUM_HDRS; i++) begin
								keep[i] = cur.name_flags[i]
									&& (cur.name_len == 8'(hrhp_pkg::HDR_LEN[i]));
							end
							nxt.name_flags = keep;
							if (keep[hrhp_pkg::HB_LENGTH]) begin
								nxt.length_acc  = 32'd0;
								nxt.length_seen = 1'b1;
							end
							nxt.close_pos   = 3'd0;
							nxt.close_ok    = 1'b1;
							nxt.field_count = '0;
							nxt.phase       = hrhp_pkg::PH_SKIP;
						end else begin
							for (int i = 0; i < hrhp_pkg::NUM_HDRS; i++) begin
								if (cur.name_len >= 8'(hrhp_pkg::HDR_LEN[i])
										|| b_low != hrhp_pkg::hdr_char(2'(i), cur.name_len)) begin
									nxt.name_flags[i] = 1'b0;
								end
							end
							if (cur.name_len != 8'd255) begin
								nxt.name_len = cur.name_len + 8'd1;
							end
						end
					end
					hrhp_pkg::PH_SKIP: begin
						if (in_byte != hrhp_pkg::CH_SP) begin
							nxt.phase = hrhp_pkg::PH_VALUE;
							val_byte  = 1'b1;
						end
					end
					hrhp_pkg::PH_VALUE: begin
						val_byte = 1'b1;
					end
					default: begin
					end
				endcase

				if (val_byte) begin
					if (in_byte == hrhp_pkg::CH_CR) begin
						if (cur.name_flags[hrhp_pkg::HB_CONN] && cur.close_ok
								&& cur.close_pos == hrhp_pkg::CLOSE_LEN) begin
							nxt.keep_alive = 1'b0;
						end
						nxt.phase = hrhp_pkg::PH_EOL;
					end else begin
						if (cur.name_flags[hrhp_pkg::HB_LENGTH] && in_byte >= hrhp_pkg::CH_ZERO
								&& in_byte <= hrhp_pkg::CH_NINE) begin
							// saturate at all ones
							nxt.length_acc = (|acc_x10[35:32]) ? 32'hFFFF_FFFF : acc_x10[31:0];
						end
						if (cur.name_flags[hrhp_pkg::HB_RANGE]) begin
							if (cur.field_count < hrhp_pkg::FCNT_W'(hrhp_pkg::VALUE_MAX_LEN - 1)) begin
								nxt.field_count = cur.field_count + 1'b1;
								tag             = hrhp_pkg::TAG_RANGE;
							end
						end else if (cur.name_flags[hrhp_pkg::HB_ACCEPT]) begin
							if (cur.field_count < hrhp_pkg::FCNT_W'(hrhp_pkg::VALUE_MAX_LEN - 1)) begin
								nxt.field_count = cur.field_count + 1'b1;
								tag             = hrhp_pkg::TAG_ACCEPT;
							end
						end
						if (cur.name_flags[hrhp_pkg::HB_CONN]) begin
							if (cur.close_pos >= hrhp_pkg::CLOSE_LEN
									|| b_low != hrhp_pkg::close_char(cur.close_pos)) begin
								nxt.close_ok = 1'b0;
							end
							if (cur.close_pos < hrhp_pkg::CLOSE_LEN) begin
								nxt.close_pos = cur.close_pos + 3'd1;
							end
						end
					end
				end

				if (in_byte == hrhp_pkg::CH_LF) begin
					nxt.line_empty = cur.last_cr;
				end else if (in_byte == hrhp_pkg::CH_CR) begin
					nxt.line_empty = cur.last_cr ? 1'b0 : cur.line_empty;
				end else begin
					nxt.line_empty = 1'b0;
				end
				nxt.last_cr = (in_byte == hrhp_pkg::CH_CR);

				if (end_line) begin
					done      = 1'b1;
					tag       = hrhp_pkg::TAG_NONE;
					nxt.phase = hrhp_pkg::PH_DONE;
				end
			end
		end
	end

	assign result = '{
		out_byte:       in_byte,
		field_tag:      tag,
		headers_done:   done,
		has_length:     nxt.length_seen,
		content_length: nxt.length_acc,
		keep_alive:     nxt.keep_alive,
		overflow:       ovf
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrhp_pkg::ST_RESET;
		end else if (step) begin
			state_q <= nxt;
		end
	end

endmodule

// ===== rtl/http_request_header_parser_top.sv =====
// result: registered, shown on m_tdata in the cycle after its input is accepted
// throughput: one byte per cycle, the next byte is taken while a result waits
// as long as m_tready is high; the parse state updates in a single pass
// reset: arst_n clears the parse state to the method phase and empties the result register
// ----------------------------------------------------------------------------
// http_request_header_parser_top
// Byte stream HTTP request header parser with a registered result stage.
// ----------------------------------------------------------------------------
module http_request_header_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	input  logic        s_tuser,  // [0] new_request
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [7:0] out_byte, [8] headers_done, [9] has_length,
	                              // [41:10] content_length, [42] keep_alive, [43] overflow
	output logic [2:0]  m_tuser   // [2:0] field_tag
);

	hrhp_pkg::hrhp_result_t result;
	hrhp_pkg::hrhp_result_t result_q;
	logic                   accept;
	logic                   valid_q;

	assign s_tready = !valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	hrhp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.in_byte     (s_tdata),
		.new_request (s_tuser),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_tready) begin
			valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = result_q.field_tag;
	assign m_tdata  = {4'd0, result_q.overflow, result_q.keep_alive, result_q.content_length,
		result_q.has_length, result_q.headers_done, result_q.out_byte};

endmodule

// ===== sim/hrhp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hrhp_checker
// Watches both stream channels of the request header parser, predicts the
// result of every accepted byte and compares it field by field in order.
// ----------------------------------------------------------------------------
module hrhp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	input  logic        s_tuser,  // [0] new_request
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,  // [7:0] out_byte, [8] headers_done, [9] has_length,
	                              // [41:10] content_length, [42] keep_alive, [43] overflow
	input  logic [2:0]  m_tuser,  // [2:0] field_tag
	output int          errors,
	output int          pending
);

	// parse state of the predictor
	hrhp_pkg::phase_t ps;
	int               fcnt;
	int               bcnt;
	logic [3:0]       hits;
	int               nlen;
	int               cpos;
	logic             cok;
	logic [31:0]      clen;
	logic             lseen;
	logic             ka;
	logic             prev_cr;
	logic             blank;

	hrhp_pkg::hrhp_result_t expected_results [$];
	int                     mism;
	int                     result_idx;

	function automatic string hdr_text(input int idx);
		case (idx)
			hrhp_pkg::HB_LENGTH: return "content-length";
			hrhp_pkg::HB_RANGE:  return "range";
			hrhp_pkg::HB_ACCEPT: return "accept";
			default:             return "connection";
		endcase
	endfunction

	function automatic logic [7:0] lc(input logic [7:0] c);
		if (c >= hrhp_pkg::CH_UP_A && c <= hrhp_pkg::CH_UP_Z)
			return c | 8'h20;
		return c;
	endfunction

	function automatic void clear_parse();
		ps      = hrhp_pkg::PH_METHOD;
		fcnt    = 0;
		bcnt    = 0;
		hits    = '1;
		nlen    = 0;
		cpos    = 0;
		cok     = 1'b1;
		clen    = '0;
		lseen   = 1'b0;
		ka      = 1'b1;
		prev_cr = 1'b0;
		blank   = 1'b1;
	endfunction

	// a limited field tags its byte only while under its length cap
	function automatic int take(input int tag, input int cap);
		if (fcnt < cap - 1) begin
			fcnt++;
			return tag;
		end
		return hrhp_pkg::TAG_NONE;
	endfunction

	function automatic int value_char(input logic [7:0] b);
		string  word;
		int     tag;
		longint nxt;
		word = "close";
		tag = hrhp_pkg::TAG_NONE;
		if (b == hrhp_pkg::CH_CR) begin
			if (hits[hrhp_pkg::HB_CONN] && cok && cpos == 5)
				ka = 1'b0;
			ps = hrhp_pkg::PH_EOL;
			return hrhp_pkg::TAG_NONE;
		end
		if (hits[hrhp_pkg::HB_LENGTH] && b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE) begin
			nxt = longint'(clen) * 10 + longint'(b - hrhp_pkg::CH_ZERO);
			clen = (nxt > 64'hFFFF_FFFF) ? '1 : nxt[31:0];
		end
		if (hits[hrhp_pkg::HB_RANGE])
			tag = take(hrhp_pkg::TAG_RANGE, hrhp_pkg::VALUE_MAX_LEN);
		else if (hits[hrhp_pkg::HB_ACCEPT])
			tag = take(hrhp_pkg::TAG_ACCEPT, hrhp_pkg::VALUE_MAX_LEN);
		if (hits[hrhp_pkg::HB_CONN]) begin
			if (cpos >= 5 || lc(b) != word[cpos])
				cok = 1'b0;
			if (cpos < 5)
				cpos++;
		end
		return tag;
	endfunction

	function automatic int name_char(input logic [7:0] b);
		logic [3:0] keep;
		string      nm;
		if (b == hrhp_pkg::CH_CR) begin
			ps = (nlen == 0) ? hrhp_pkg::PH_END : hrhp_pkg::PH_EOL;
			return hrhp_pkg::TAG_NONE;
		end
		if (b == hrhp_pkg::CH_COLON) begin
			keep = '0;
			for (int i = 0; i < hrhp_pkg::NUM_HDRS; i++) begin
				nm = hdr_text(i);
				if (hits[i] && nlen == nm.len())
					keep[i] = 1'b1;
			end
			hits = keep;
			if (keep[hrhp_pkg::HB_LENGTH]) begin
				clen  = '0;
				lseen = 1'b1;
			end
			cpos = 0;
			cok  = 1'b1;
			fcnt = 0;
			ps   = hrhp_pkg::PH_SKIP;
			return hrhp_pkg::TAG_NONE;
		end
		// exact length match: a longer name drops every candidate
		for (int i = 0; i < hrhp_pkg::NUM_HDRS; i++) begin
			nm = hdr_text(i);
			if (nlen >= nm.len() || lc(b) != nm[nlen])
				hits[i] = 1'b0;
		end
		if (nlen < 255)
			nlen++;
		return hrhp_pkg::TAG_NONE;
	endfunction

	function automatic int parse_char(input logic [7:0] b);
		case (ps)
			hrhp_pkg::PH_METHOD: begin
				if (b == hrhp_pkg::CH_CR) begin
					ps = hrhp_pkg::PH_EOL;
					return hrhp_pkg::TAG_NONE;
				end
				if (b == hrhp_pkg::CH_SP) begin
					ps   = hrhp_pkg::PH_PATH;
					fcnt = 0;
					return hrhp_pkg::TAG_NONE;
				end
				return take(hrhp_pkg::TAG_METHOD, hrhp_pkg::METHOD_MAX);
			end
			hrhp_pkg::PH_PATH: begin
				if (b == hrhp_pkg::CH_CR) begin
					ps = hrhp_pkg::PH_EOL;
					return hrhp_pkg::TAG_NONE;
				end
				if (b == hrhp_pkg::CH_SP) begin
					ps = hrhp_pkg::PH_LINE;
					return hrhp_pkg::TAG_NONE;
				end
				if (b == hrhp_pkg::CH_QMARK) begin
					ps   = hrhp_pkg::PH_QUERY;
					fcnt = 0;
					return hrhp_pkg::TAG_NONE;
				end
				return take(hrhp_pkg::TAG_PATH, hrhp_pkg::PATH_MAX_LEN);
			end
			hrhp_pkg::PH_QUERY: begin
				if (b == hrhp_pkg::CH_CR) begin
					ps = hrhp_pkg::PH_EOL;
					return hrhp_pkg::TAG_NONE;
				end
				if (b == hrhp_pkg::CH_SP) begin
					ps = hrhp_pkg::PH_LINE;
					return hrhp_pkg::TAG_NONE;
				end
				return take(hrhp_pkg::TAG_QUERY, hrhp_pkg::QUERY_MAX_LEN);
			end
			hrhp_pkg::PH_LINE: begin
				if (b == hrhp_pkg::CH_CR)
					ps = hrhp_pkg::PH_EOL;
				return hrhp_pkg::TAG_NONE;
			end
			hrhp_pkg::PH_EOL: begin
				// byte after a CR is skipped, a new header name starts
				ps   = hrhp_pkg::PH_NAME;
				hits = '1;
				nlen = 0;
				return hrhp_pkg::TAG_NONE;
			end
			hrhp_pkg::PH_NAME: return name_char(b);
			hrhp_pkg::PH_SKIP: begin
				if (b == hrhp_pkg::CH_SP)
					return hrhp_pkg::TAG_NONE;
				ps = hrhp_pkg::PH_VALUE;
				return value_char(b);
			end
			hrhp_pkg::PH_VALUE: return value_char(b);
			default:            return hrhp_pkg::TAG_NONE;
		endcase
	endfunction

	function automatic hrhp_pkg::hrhp_result_t parse_step(input logic [7:0] b, input logic nr);
		hrhp_pkg::hrhp_result_t r;
		int                     tag;
		logic                   done;
		logic                   ovf;
		logic                   end_hdr;
		tag  = hrhp_pkg::TAG_NONE;
		done = 1'b0;
		ovf  = 1'b0;
		if (nr)
			clear_parse();
		if (ps != hrhp_pkg::PH_DONE) begin
			if (bcnt >= hrhp_pkg::HEADER_MAX) begin
				ovf = 1'b1;
			end else begin
				bcnt++;
				end_hdr = (b == hrhp_pkg::CH_LF) && prev_cr && blank;
				tag = parse_char(b);
				if (b == hrhp_pkg::CH_LF)
					blank = prev_cr;
				else if (b == hrhp_pkg::CH_CR)
					blank = prev_cr ? 1'b0 : blank;
				else
					blank = 1'b0;
				prev_cr = (b == hrhp_pkg::CH_CR);
				if (end_hdr) begin
					done = 1'b1;
					tag  = hrhp_pkg::TAG_NONE;
					ps   = hrhp_pkg::PH_DONE;
				end
			end
		end
		r.out_byte       = b;
		r.field_tag      = hrhp_pkg::field_tag_t'(3'(tag));
		r.headers_done   = done;
		r.has_length     = lseen;
		r.content_length = clen;
		r.keep_alive     = ka;
		r.overflow       = ovf;
		return r;
	endfunction

	task automatic compare_result();
		hrhp_pkg::hrhp_result_t got;
		hrhp_pkg::hrhp_result_t want;
		logic                   bad;
		got.out_byte       = m_tdata[7:0];
		got.field_tag      = hrhp_pkg::field_tag_t'(m_tuser);
		got.headers_done   = m_tdata[8];
		got.has_length     = m_tdata[9];
		got.content_length = m_tdata[41:10];
		got.keep_alive     = m_tdata[42];
		got.overflow       = m_tdata[43];
		if (expected_results.size() == 0) begin
			mism++;
			if (mism <= 10)
				$display("result %0d: unexpected transaction, byte %h tag %0d",
					result_idx, got.out_byte, got.field_tag);
		end else begin
			want = expected_results.pop_front();
			bad = (got.out_byte !== want.out_byte) || (got.field_tag !== want.field_tag)
				|| (got.headers_done !== want.headers_done)
				|| (got.has_length !== want.has_length)
				|| (got.content_length !== want.content_length)
				|| (got.keep_alive !== want.keep_alive) || (got.overflow !== want.overflow);
			if (bad) begin
				mism++;
				if (mism <= 10) begin
					$display({"result %0d mismatch: byte %h tag %0d done %b",
						" has_len %b len %0d keep %b ovf %b"},
						result_idx, got.out_byte, got.field_tag, got.headers_done,
						got.has_length, got.content_length, got.keep_alive, got.overflow);
					$display({"  expected:      byte %h tag %0d done %b",
						" has_len %b len %0d keep %b ovf %b"},
						want.out_byte, want.field_tag, want.headers_done, want.has_length,
						want.content_length, want.keep_alive, want.overflow);
				end
			end
		end
		result_idx++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			expected_results.delete();
			mism = 0;
			result_idx = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// the result of a byte accepted at this edge is queued until it shows up on the output
			if (m_tvalid && m_tready)
				compare_result();
			if (s_tvalid && s_tready)
				expected_results.push_back(parse_step(s_tdata, s_tuser));
			errors  <= mism;
			pending <= expected_results.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds HTTP request headers byte by byte into the parser: a few directed
// corner cases, then random well formed requests with random content, broken
// and truncated requests and noise, under changing sender and receiver idle
// patterns.
// ----------------------------------------------------------------------------
module testbench;

	localparam string ALNUM =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/._-~%=&";
	localparam string UPPER = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
	localparam string VALCH =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 ,;*/=:?";

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;

	int errors;
	int pending;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int rx_hold_len = 0;
	int rx_hold_left = 0;
	int items_sent = 0;

	logic [7:0] byte_q [$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	http_request_header_parser_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	hrhp_checker check_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (rx_hold_len > 0) begin
			rx_hold_left = rx_hold_len;
			rx_hold_len = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("[http_request_header_parser_top] ERROR");
		$finish;
	end

	task automatic set_mode(input int mode);
		case (mode)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
			default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b, input logic nr);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= nr;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_seq(input int n, input logic fresh);
		for (int i = 0; i < n; i++)
			push_byte(byte_q[i], fresh && (i == 0));
	endtask

	// sender stops until every expected result has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			byte_q.push_back(s[i]);
	endtask

	task automatic add_eol();
		byte_q.push_back(hrhp_pkg::CH_CR);
		byte_q.push_back(hrhp_pkg::CH_LF);
	endtask

	task automatic add_spaces();
		int n;
		n = $urandom_range(2);
		repeat (n) byte_q.push_back(hrhp_pkg::CH_SP);
	endtask

	task automatic add_digits(input int n);
		repeat (n) byte_q.push_back(hrhp_pkg::CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic add_chars(input int n, input string alpha);
		repeat (n) byte_q.push_back(alpha[$urandom_range(alpha.len() - 1)]);
	endtask

	function automatic string rand_case(input string s);
		string t;
		t = s;
		for (int i = 0; i < t.len(); i++)
			if (((t[i] >= "a" && t[i] <= "z") || (t[i] >= "A" && t[i] <= "Z"))
				&& $urandom_range(1))
				t[i] = t[i] ^ 8'h20;
		return t;
	endfunction

	// mostly short fields, now and then one that crosses its cap
	function automatic int pick_len(input int cap);
		if ($urandom_range(19) == 0)
			return $urandom_range(cap + 14, cap - 6);
		return $urandom_range(12);
	endfunction

	task automatic add_header();
		case ($urandom_range(9))
			0, 1: begin
				add_text(rand_case("Content-Length"));
				add_text(":");
				add_spaces();
				add_digits(($urandom_range(4) == 0) ? $urandom_range(14, 9)
					: $urandom_range(6, 1));
				if ($urandom_range(5) == 0) begin
					add_text("x");
					add_digits(2);
				end
			end
			2: begin
				add_text(rand_case("Range"));
				add_text(":");
				add_spaces();
				if ($urandom_range(3) == 0) begin
					add_chars(pick_len(hrhp_pkg::VALUE_MAX_LEN), VALCH);
				end else begin
					add_text("bytes=");
					add_digits($urandom_range(4, 1));
					add_text("-");
					add_digits($urandom_range(4));
				end
			end
			3: begin
				add_text(rand_case("Accept"));
				add_text(":");
				add_spaces();
				if ($urandom_range(3) == 0)
					add_text("*/*");
				else
					add_chars(pick_len(hrhp_pkg::VALUE_MAX_LEN), VALCH);
			end
			4: begin
				add_text(rand_case("Connection"));
				add_text(":");
				add_spaces();
				case ($urandom_range(4))
					0, 1: add_text(rand_case("close"));
					2:    add_text(rand_case("keep-alive"));
					3:    add_text(rand_case("closed"));
					default: add_text(rand_case("clos"));
				endcase
			end
			5: begin
				case ($urandom_range(4))
					0: add_text(rand_case("Content-Lengt"));
					1: add_text(rand_case("Ranges"));
					2: add_text(rand_case("Accep"));
					3: add_text(rand_case("Connection-X"));
					default: add_text("Content-Length ");
				endcase
				add_text(": ");
				add_digits(3);
			end
			6: add_text("X-No-Colon value");
			7: begin
				add_text(rand_case("Range"));
				add_text(":");
			end
			default: begin
				add_text(rand_case("Host"));
				add_text(": ");
				add_chars($urandom_range(12), VALCH);
			end
		endcase
		add_eol();
	endtask

	task automatic build_request();
		int nh;
		byte_q.delete();
		case ($urandom_range(4))
			0: add_text("GET");
			1: add_text("POST");
			2: add_text("HEAD");
			3: add_text("PUT");
			default: add_chars(pick_len(hrhp_pkg::METHOD_MAX), UPPER);
		endcase
		add_text(" /");
		add_chars(pick_len(hrhp_pkg::PATH_MAX_LEN), ALNUM);
		if ($urandom_range(1)) begin
			add_text("?");
			add_chars(pick_len(hrhp_pkg::QUERY_MAX_LEN), {ALNUM, "?"});
		end
		if ($urandom_range(9) != 0)
			add_text(" HTTP/1.1");
		add_eol();
		nh = $urandom_range(6);
		repeat (nh) add_header();
		add_eol();
		// bytes after the blank line carry no tag
		if ($urandom_range(3) == 0)
			add_chars($urandom_range(3, 1), VALCH);
	endtask

	initial begin
		int req;
		int pick;
		int n;

		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// leading blank line ends the headers at once
		byte_q = '{hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};
		send_seq(2, 1'b1);
		// extreme byte values after done
		byte_q = '{8'h00, 8'hFF};
		send_seq(2, 1'b0);
		byte_q.delete();
		add_text("A /p?q");
		add_eol();
		add_text("Range: 5");
		add_eol();
		add_eol();
		send_seq(byte_q.size(), 1'b1);
		drain();

		req = 0;
		while (items_sent < 1330) begin
			if (req % 10 == 0)
				set_mode((req / 10) % 4);
			pick = $urandom_range(9);
			if (req == 45) begin
				// long receiver hold-off while the sender keeps offering bytes
				rx_hold_len = 200;
				pick = 9;
			end
			if (req == 70)
				drain();
			case (pick)
				0: begin
					n = $urandom_range(30, 1);
					for (int i = 0; i < n; i++)
						push_byte(8'($urandom_range(255)), (i == 0) || ($urandom_range(15) == 0));
				end
				1: begin
					build_request();
					send_seq($urandom_range(byte_q.size(), 1), 1'b1);
				end
				2: begin
					byte_q = '{hrhp_pkg::CH_CR, hrhp_pkg::CH_LF};
					send_seq(2, 1'b1);
				end
				default: begin
					build_request();
					send_seq(byte_q.size(), 1'b1);
				end
			endcase
			req++;
		end

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[http_request_header_parser_top] OK");
		else
			$display("[http_request_header_parser_top] ERROR");
		$finish;
	end

endmodule
